[design/weca_pkg.sv]
// weca_pkg: shared constants, codes and types for the windowed event count alarm.
// No dependencies; imported by weca_cell, weca_chain and the top level.
package weca_pkg;

  localparam int unsigned WECA_MAX_COUNT = 16;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TRIG_W     = 5;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_DATA_W   = 40;
  localparam int unsigned M_DATA_W   = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_MSG   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_HIT   = 2'd2,
    CMD_CLEAR = 2'd3
  } weca_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER  = 3'd0,
    REG_WINDOW   = 3'd1,
    REG_AT_LEAST = 3'd2,
    REG_AT_MOST  = 3'd3,
    REG_PERSIST  = 3'd4
  } weca_reg_e;

  // One-cycle operation broadcast to every cell of the chain
  typedef struct packed {
    logic clear;       // drop all entries
    logic shift;       // append: shift stamps and valids one place
    logic shift_keep;  // drop oldest and append: shift stamps, valids stay
    logic pop;         // drop oldest entry
    logic trim;        // keep only the newest limit entries
  } weca_cell_ctl_t;

endpackage

[design/windowed_event_count_alarm_top.sv]
// windowed_event_count_alarm_top: sliding window event count alarm cell.
// An unlatched message beat walks EXPIRE, dropping expired entries one per cycle from the oldest
// cell and then trimming to the trigger count, then FINISH and DONE; latched message, tick, hit
// and clear beats go straight to DONE. DONE loads the result into the output register once it is
// free; a new beat is taken only in IDLE, and the output register lets it in while the result waits.
// Reset (rst_ni low, async): chain empty, cell off, event time 0.
module windowed_event_count_alarm_top import weca_pkg::*; #(
  parameter int unsigned MAX_COUNT = WECA_MAX_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,  // [31:0] time_value, [32] hit_value
  input  logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] command
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata   // [0] flipped, [1] cell_on,
                                               // [2] schedule_valid, [34:3] schedule_time
);

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXPIRE,
    S_FINISH,
    S_DONE
  } state_e;

  // Config registers
  logic [TRIG_W-1:0] trig_q;
  logic [TIME_W-1:0] window_q;
  logic              at_least_q, at_most_q, persist_q;

  // Control and result state
  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              on_q, on_d;
  logic              def_q, def_d;
  logic [TIME_W-1:0] event_q, event_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic              flip_q, flip_d;
  logic              sched_q, sched_d;
  logic [TIME_W-1:0] schtime_q, schtime_d;
  logic              out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;

  // Chain interface
  weca_cell_ctl_t    ctl;
  logic [CW-1:0]     tc;
  logic [MAX_COUNT-1:0] chain_valid;
  logic [TIME_W-1:0] oldest_stamp;
  logic              oldest_expired;

  // Decoded input beat
  weca_cmd_e         in_cmd;
  logic [TIME_W-1:0] in_time;
  logic              in_hit;
  logic              next_on;
  logic              full;

  assign in_cmd  = weca_cmd_e'(s_axis_tuser);
  assign in_time = s_axis_tdata[TIME_W-1:0];
  assign in_hit  = s_axis_tdata[TIME_W];

  // Effective trigger count: zero acts as one, clipped to the chain length
  always_comb begin
    if (trig_q == '0) begin
      tc = CW'(1);
    end else if (32'(trig_q) > MAX_COUNT) begin
      tc = CW'(MAX_COUNT);
    end else begin
      tc = CW'(trig_q);
    end
  end

  //--------------------------------------------------------------------------
  // Config writes (the user must write only while idle; the block itself does not enforce it)
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q     <= TRIG_W'(1);
      window_q   <= '0;
      at_least_q <= 1'b0;
      at_most_q  <= 1'b0;
      persist_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRIGGER:  trig_q     <= cfg_data_i[TRIG_W-1:0];
        REG_WINDOW:   window_q   <= cfg_data_i[TIME_W-1:0];
        REG_AT_LEAST: at_least_q <= cfg_data_i[0];
        REG_AT_MOST:  at_most_q  <= cfg_data_i[0];
        REG_PERSIST:  persist_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Timestamp chain
  //--------------------------------------------------------------------------
  weca_chain #(
    .N  (MAX_COUNT),
    .CW (CW)
  ) u_chain (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .limit_i          (tc),
    .push_stamp_i     (in_time),
    .ref_time_i       (time_q),
    .window_i         (window_q),
    .valid_o          (chain_valid),
    .oldest_stamp_o   (oldest_stamp),
    .oldest_expired_o (oldest_expired)
  );

  //--------------------------------------------------------------------------
  // Sequencer
  //   IDLE:   take a beat; append message (rotate if latched) / resolve tick, hit, clear at once
  //   EXPIRE: drop one expired oldest per cycle; on exit trim to trigger count
  //   FINISH: fill check, schedule, new on state
  //   DONE:   load output register once it is free
  //--------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign full          = (count_q == tc);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    on_d        = on_q;
    def_d       = def_q;
    event_d     = event_q;
    time_d      = time_q;
    flip_d      = flip_q;
    sched_d     = sched_q;
    schtime_d   = schtime_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctl         = '0;
    next_on     = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          time_d    = in_time;
          flip_d    = 1'b0;
          sched_d   = 1'b0;
          schtime_d = '0;
          state_d   = S_DONE;
          unique case (in_cmd)
            CMD_MSG: begin
              if (on_q && persist_q) begin
                // latched: oldest out, new one in, count unchanged
                if (count_q != '0) begin
                  ctl.shift_keep = 1'b1;
                end
              end else begin
                ctl.shift = 1'b1;
                if (count_q != CW'(MAX_COUNT)) begin
                  count_d = count_q + CW'(1);
                end
                state_d = S_EXPIRE;
              end
            end
            CMD_TICK: begin
              if (in_time == event_q) begin
                next_on = at_most_q | persist_q;
                flip_d  = next_on ^ on_q;
                on_d    = next_on;
              end
            end
            CMD_HIT: begin
              if (!def_q) begin
                def_d  = 1'b1;
                on_d   = in_hit;
                flip_d = 1'b1;
              end else if (in_hit != on_q) begin
                on_d   = in_hit;
                flip_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
              count_d   = '0;
              on_d      = 1'b0;
              def_d     = 1'b0;
              event_d   = '0;
            end
            default: ;
          endcase
        end
      end

      S_EXPIRE: begin
        if (count_q > CW'(1) && oldest_expired) begin
          ctl.pop = 1'b1;
          count_d = count_q - CW'(1);
        end else begin
          if (count_q > tc) begin
            ctl.trim = 1'b1;
            count_d  = tc;
          end
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (full || at_most_q) begin
          event_d   = oldest_stamp + window_q + TIME_W'(1);
          sched_d   = 1'b1;
          schtime_d = oldest_stamp + window_q + TIME_W'(1);
        end
        next_on = full & at_least_q;
        flip_d  = next_on ^ on_q;
        on_d    = next_on;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = M_DATA_W'({schtime_q, sched_q, on_q, flip_q});
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      on_q        <= 1'b0;
      def_q       <= 1'b0;
      event_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      on_q        <= on_d;
      def_q       <= def_d;
      event_q     <= event_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-beat payload, no reset needed
  always_ff @(posedge clk_i) begin
    time_q     <= time_d;
    flip_q     <= flip_d;
    sched_q    <= sched_d;
    schtime_q  <= schtime_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  // fill count tracks the thermometer of valid cells
  a_count_matches_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_valid) == int'(count_q))
    else $error("fill count out of step with chain valids");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(MAX_COUNT))
    else $error("fill count above chain length");

  // a clear beat empties the cell and turns it off
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR)
      |=> (count_q == '0 && !on_q && !def_q && event_q == '0))
    else $error("clear beat left state behind");

  // a finished result waits in DONE while the output register is held
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_axis_tready) |=> state_q == S_DONE)
    else $error("result dropped while output stalled");

  // expiry walk never leaves the window holding more than the trigger count
  a_trim_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> (count_q <= tc && count_q != '0))
    else $error("window not trimmed before finish");

endmodule

[design/weca_cell.sv]
// weca_cell: one timestamp slot of the chain; newest entries sit at low indexes.
// Depends on weca_pkg.
module weca_cell import weca_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  weca_cell_ctl_t    ctl_i,
  input  logic [CW-1:0]     limit_i,
  input  logic [TIME_W-1:0] ref_time_i,
  input  logic [TIME_W-1:0] window_i,
  input  logic [TIME_W-1:0] prev_stamp_i,
  input  logic              prev_valid_i,
  input  logic              next_valid_i,
  output logic [TIME_W-1:0] stamp_o,
  output logic              valid_o,
  output logic              oldest_o,
  output logic              expired_o
);

  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic              valid_q, valid_d;
  logic [TIME_W-1:0] age;
  logic              keep_ok;

  assign oldest_o  = valid_q & ~next_valid_i;
  assign age       = ref_time_i - stamp_q;   // wraps mod 2^32
  assign expired_o = valid_q & (age > window_i);
  assign keep_ok   = CW'(IDX) < limit_i;
  assign stamp_o   = stamp_q;
  assign valid_o   = valid_q;

  always_comb begin
    valid_d = valid_q;
    stamp_d = stamp_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      valid_d = prev_valid_i;
      stamp_d = prev_stamp_i;
    end else if (ctl_i.shift_keep) begin
      stamp_d = prev_stamp_i;
    end else if (ctl_i.pop) begin
      valid_d = valid_q & ~oldest_o;
    end else if (ctl_i.trim) begin
      valid_d = valid_q & keep_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
  end

endmodule

[design/weca_chain.sv]
// weca_chain: row of weca_cell slots plus the pick of the oldest entry.
// Depends on weca_pkg and weca_cell.
module weca_chain import weca_pkg::*; #(
  parameter int unsigned N  = WECA_MAX_COUNT,
  parameter int unsigned CW = $clog2(N + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  weca_cell_ctl_t    ctl_i,
  input  logic [CW-1:0]     limit_i,
  input  logic [TIME_W-1:0] push_stamp_i,
  input  logic [TIME_W-1:0] ref_time_i,
  input  logic [TIME_W-1:0] window_i,
  output logic [N-1:0]      valid_o,
  output logic [TIME_W-1:0] oldest_stamp_o,
  output logic              oldest_expired_o
);

  logic [TIME_W-1:0] stamp_w [N];
  logic [N-1:0]      valid_w;
  logic [N-1:0]      oldest_w;
  logic [N-1:0]      expired_w;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [TIME_W-1:0] prev_stamp;
    logic              prev_valid;
    logic              next_valid;

    if (g == 0) begin : g_head
      assign prev_stamp = push_stamp_i;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_stamp = stamp_w[g-1];
      assign prev_valid = valid_w[g-1];
    end

    if (g == N - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_valid = valid_w[g+1];
    end

    weca_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .limit_i      (limit_i),
      .ref_time_i   (ref_time_i),
      .window_i     (window_i),
      .prev_stamp_i (prev_stamp),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .stamp_o      (stamp_w[g]),
      .valid_o      (valid_w[g]),
      .oldest_o     (oldest_w[g]),
      .expired_o    (expired_w[g])
    );
  end

  // Valids form a thermometer, so at most one cell flags itself oldest
  always_comb begin
    oldest_stamp_o   = '0;
    oldest_expired_o = 1'b0;
    for (int i = 0; i < N; i++) begin
      oldest_stamp_o   = oldest_stamp_o | (stamp_w[i] & {TIME_W{oldest_w[i]}});
      oldest_expired_o = oldest_expired_o | (oldest_w[i] & expired_w[i]);
    end
  end

  assign valid_o = valid_w;

endmodule

[bench/windowed_event_count_alarm_top_tb.sv]
`timescale 1ns / 1ps
// windowed_event_count_alarm_top_tb: self-checking bench for the windowed event count alarm.
// Needs weca_pkg and windowed_event_count_alarm_top. It predicts every result beat with its own
// alarm-cell model, which tracks the config writes.
module windowed_event_count_alarm_top_tb;
  import weca_pkg::*;

  localparam int unsigned RING_DEPTH  = WECA_MAX_COUNT;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with nothing accepted while busy
  localparam int unsigned HOLD_CYCLES = 300;   // long sink hold-off, fills the block
  localparam int unsigned MAX_REPORTS = 10;

  // One result beat, as the model predicts it
  typedef struct packed {
    logic              flipped;
    logic              cell_on;
    logic              sched_valid;
    logic [TIME_W-1:0] sched_time;
  } alarm_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // [31:0] time_value, [32] hit_value
  logic [CMD_W-1:0]      s_axis_tuser  = '0;  // [1:0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;        // [0] flipped, [1] cell_on,
                                              // [2] schedule_valid, [34:3] schedule_time

  windowed_event_count_alarm_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Alarm-cell model: config copy, timestamp history and flags, reset values.
  // ---------------------------------------------------------------------------
  logic [TRIG_W-1:0] trig_cfg    = 5'd1;
  logic [TIME_W-1:0] window_cfg  = '0;
  logic              least_cfg   = 1'b0;
  logic              most_cfg    = 1'b0;
  logic              persist_cfg = 1'b0;

  logic [TIME_W-1:0] stamp_hist [RING_DEPTH];
  int                hist_head      = 0;  // oldest entry
  int                hist_count     = 0;
  logic              cell_on_q      = 1'b0;
  logic              cell_defined_q = 1'b0;
  logic [TIME_W-1:0] check_time     = '0;  // pending timing check

  alarm_result_t expected_results [$];

  int unsigned fault_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq       = 0;  // bumped by a test to request a sink hold-off
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;

  function automatic void drop_oldest_stamp();
    if (hist_count != 0) begin
      hist_head = (hist_head + 1) % RING_DEPTH;
      hist_count--;
    end
  endfunction

  // A full history loses its oldest stamp
  function automatic void push_stamp(input logic [TIME_W-1:0] t);
    if (hist_count >= RING_DEPTH) drop_oldest_stamp();
    stamp_hist[(hist_head + hist_count) % RING_DEPTH] = t;
    hist_count++;
  endfunction

  function automatic alarm_result_t predict_alarm(input weca_cmd_e cmd,
                                                  input logic [TIME_W-1:0] t,
                                                  input logic hv);
    alarm_result_t     res;
    int                fill;
    logic              new_on;
    logic [TIME_W-1:0] age;
    res    = '0;
    new_on = 1'b0;
    case (cmd)
      CMD_MSG: begin
        if (cell_on_q && persist_cfg) begin
          // latched: rotate the history, an empty one stays empty
          if (hist_count > 0) begin
            drop_oldest_stamp();
            push_stamp(t);
          end
        end else begin
          // trigger count clamps to 1..RING_DEPTH
          fill = (trig_cfg == 0) ? 1 :
                 ((trig_cfg > RING_DEPTH) ? int'(RING_DEPTH) : int'(trig_cfg));
          push_stamp(t);
          age = t - stamp_hist[hist_head];  // mod 2^32
          while (hist_count > 1 && age > window_cfg) begin
            drop_oldest_stamp();
            age = t - stamp_hist[hist_head];
          end
          while (hist_count > fill) drop_oldest_stamp();
          if (hist_count == fill || most_cfg) begin
            if (hist_count == fill) new_on = least_cfg;
            check_time      = stamp_hist[hist_head] + window_cfg + 32'd1;
            res.sched_valid = 1'b1;
            res.sched_time  = check_time;
          end
          res.flipped = (new_on != cell_on_q);
          cell_on_q   = new_on;
        end
      end
      CMD_TICK: begin
        if (t == check_time) begin
          new_on      = most_cfg | persist_cfg;
          res.flipped = (new_on != cell_on_q);
          cell_on_q   = new_on;
        end
      end
      CMD_HIT: begin
        // first hit defines the flag and always reports a flip
        if (!cell_defined_q) begin
          cell_defined_q = 1'b1;
          cell_on_q      = hv;
          res.flipped    = 1'b1;
        end else if (hv != cell_on_q) begin
          cell_on_q   = hv;
          res.flipped = 1'b1;
        end
      end
      CMD_CLEAR: begin
        hist_head      = 0;
        hist_count     = 0;
        cell_on_q      = 1'b0;
        cell_defined_q = 1'b0;
        check_time     = '0;
      end
    endcase
    res.cell_on = cell_on_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, plus a long hold-off when a test asks for one.
  // tready only changes at the rising edge, so a beat's fate is known at negedge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic log_fault(input string what, input logic [TIME_W-1:0] want_v,
                           input logic [TIME_W-1:0] got_v);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
  endtask

  // Result check, at negedge: a beat valid and ready here is taken at the next edge
  always @(negedge clk_i) begin : result_check
    alarm_result_t want;
    alarm_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.flipped     = m_axis_tdata[0];
      got.cell_on     = m_axis_tdata[1];
      got.sched_valid = m_axis_tdata[2];
      got.sched_time  = m_axis_tdata[34:3];
      if (expected_results.size() == 0) begin
        log_fault("result beat with none pending, tdata", '0, m_axis_tdata[31:0]);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got.flipped !== want.flipped)
          log_fault("flipped", TIME_W'(want.flipped), TIME_W'(got.flipped));
        if (got.cell_on !== want.cell_on)
          log_fault("cell_on", TIME_W'(want.cell_on), TIME_W'(got.cell_on));
        if (got.sched_valid !== want.sched_valid)
          log_fault("schedule_valid", TIME_W'(want.sched_valid), TIME_W'(got.sched_valid));
        if (got.sched_time !== want.sched_time)
          log_fault("schedule_time", want.sched_time, got.sched_time);
      end
    end
  end

  // Watchdog: busy but no beat moving on either side for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else if (s_axis_tvalid || expected_results.size() != 0)
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("windowed_event_count_alarm_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side. Called at a rising edge, returns at the edge that took the beat
  // with tvalid still high, so back-to-back beats never drop tvalid.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input weca_cmd_e cmd, input logic [TIME_W-1:0] t,
                           input logic hv);
    alarm_result_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({hv, t});
    s_axis_tuser  <= cmd;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    pred = predict_alarm(cmd, t, hv);
    expected_results.insert(expected_results.size(), pred);
  endtask

  // Stop sending and wait until every result is back; the block is idle after
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all five registers back to back, mirrors them into the model
  task automatic write_config(input logic [TRIG_W-1:0] trig, input logic [TIME_W-1:0] win,
                              input logic least, input logic most, input logic persist);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TRIGGER;
    cfg_data_i <= CFG_DATA_W'(trig);
    @(posedge clk_i);
    cfg_idx_i  <= REG_WINDOW;
    cfg_data_i <= win;
    @(posedge clk_i);
    cfg_idx_i  <= REG_AT_LEAST;
    cfg_data_i <= CFG_DATA_W'(least);
    @(posedge clk_i);
    cfg_idx_i  <= REG_AT_MOST;
    cfg_data_i <= CFG_DATA_W'(most);
    @(posedge clk_i);
    cfg_idx_i  <= REG_PERSIST;
    cfg_data_i <= CFG_DATA_W'(persist);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    trig_cfg    = trig;
    window_cfg  = win;
    least_cfg   = least;
    most_cfg    = most;
    persist_cfg = persist;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Defaults out of reset: event time 0 matches a tick at 0, a single message fills
  task automatic test_power_on();
    send_beat(CMD_TICK, 32'd0, 1'b0);
    send_beat(CMD_TICK, 32'd5, 1'b1);
    send_beat(CMD_MSG, 32'd100, 1'b1);
    send_beat(CMD_TICK, check_time, 1'b0);  // neither at-most nor persistent: off
  endtask

  // First hit defines the flag, later ones only report changes
  task automatic test_direct_hits();
    send_beat(CMD_HIT, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_HIT, 32'd0, 1'b0);
    send_beat(CMD_HIT, 32'd1, 1'b1);
    send_beat(CMD_HIT, 32'd2, 1'b1);
    send_beat(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_beat(CMD_HIT, 32'd3, 1'b1);
  endtask

  // Expiry across the 2^32 wrap; age equal to the window is kept
  task automatic test_window_expiry();
    wait_drained();
    write_config(5'd3, 32'd10, 1'b1, 1'b0, 1'b0);
    send_beat(CMD_CLEAR, 32'd0, 1'b0);
    send_beat(CMD_MSG, 32'hFFFF_FFF8, 1'b0);
    send_beat(CMD_MSG, 32'hFFFF_FFFC, 1'b0);
    send_beat(CMD_MSG, 32'h0000_0002, 1'b0);  // full window, on
    send_beat(CMD_MSG, 32'h0000_000D, 1'b0);  // drops three, off
    send_beat(CMD_TICK, check_time, 1'b0);
  endtask

  // Persistent latch: latched messages rotate history, ticks keep the cell on
  task automatic test_latched_cell();
    wait_drained();
    write_config(5'd2, 32'd100, 1'b1, 1'b1, 1'b1);
    send_beat(CMD_CLEAR, 32'd0, 1'b0);
    send_beat(CMD_HIT, 32'd0, 1'b1);
    send_beat(CMD_MSG, 32'd50, 1'b0);  // empty history stays empty
    send_beat(CMD_CLEAR, 32'd0, 1'b0);
    send_beat(CMD_MSG, 32'd60, 1'b0);
    send_beat(CMD_MSG, 32'd70, 1'b0);
    send_beat(CMD_MSG, 32'd80, 1'b1);
    send_beat(CMD_TICK, check_time, 1'b0);
  endtask

  // Trigger count of 0 acts as 1, above the ring depth as the depth
  task automatic test_trigger_clamps();
    wait_drained();
    write_config(5'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_beat(CMD_MSG, 32'd7, 1'b0);
    send_beat(CMD_MSG, 32'd7, 1'b1);
    wait_drained();
    write_config(5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_beat(CMD_MSG, 32'd0, 1'b0);
    send_beat(CMD_MSG, 32'hFFFF_FFFF, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly ordered message streams that fill the window,
  // ticks that mostly hit the scheduled time, some noise.
  // ---------------------------------------------------------------------------
  task automatic run_random_segment(input int n_items);
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] t;
    int                sel;
    int                span;
    now_t = ($urandom_range(3) == 0) ? 32'hFFFF_FF80 : $urandom;
    span  = (window_cfg > 40) ? 40 : int'(window_cfg);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        now_t += $urandom_range(span / 2 + 2);
        send_beat(CMD_MSG, now_t, 1'($urandom_range(1)));
      end else if (sel < 65) begin
        send_beat(CMD_MSG, $urandom, 1'($urandom_range(1)));  // out-of-order stamp
      end else if (sel < 82) begin
        if ($urandom_range(4) != 0) t = check_time;
        else t = $urandom_range(1) ? now_t : $urandom;
        send_beat(CMD_TICK, t, 1'($urandom_range(1)));
      end else if (sel < 97) begin
        send_beat(CMD_HIT, $urandom, 1'($urandom_range(1)));
      end else begin
        send_beat(CMD_CLEAR, $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic pick_random_config();
    logic [TRIG_W-1:0] trig;
    logic [TIME_W-1:0] win;
    case ($urandom_range(9))
      7:       trig = 5'd0;
      8:       trig = 5'd16;
      9:       trig = TRIG_W'($urandom_range(31, 17));
      default: trig = TRIG_W'($urandom_range(5, 1));
    endcase
    case ($urandom_range(3))
      0:       win = '0;
      1:       win = $urandom_range(40, 1);
      2:       win = 32'hFFFF_FFFF;
      default: win = $urandom;
    endcase
    write_config(trig, win, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
  endtask

  // Four idle profiles, two config settings each; the first profile uses the extremes, the second opens with trigger 16
  task automatic test_random_traffic();
    int unsigned send_pct [4] = '{0, 52, 0, 16};
    int unsigned recv_pct [4] = '{0, 0, 52, 16};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int seg = 0; seg < 2; seg++) begin
        wait_drained();
        if (phase == 0 && seg == 0) write_config(5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        else if (phase == 0) write_config(5'd0, 32'd0, 1'b1, 1'b1, 1'b0);
        else if (phase == 1 && seg == 0) write_config(5'd16, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        else pick_random_config();
        run_random_segment(240);
      end
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering beats,
  // then the source pauses until everything is back
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_config(5'd2, 32'd20, 1'b1, 1'b1, 1'b0);
    @(negedge clk_i);
    hold_seq++;
    @(posedge clk_i);
    run_random_segment(60);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on();
    test_direct_hits();
    test_window_expiry();
    test_latched_cell();
    test_trigger_clamps();
    test_backpressure();
    test_random_traffic();

    // all results back, then a few cycles for anything stray
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && expected_results.size() == 0)
      $display("windowed_event_count_alarm_top verification clean");
    else
      $display("windowed_event_count_alarm_top verification failed");
    $finish;
  end

endmodule

[files.f]
design/weca_pkg.sv
design/weca_cell.sv
design/weca_chain.sv
design/windowed_event_count_alarm_top.sv
bench/windowed_event_count_alarm_top_tb.sv
